FILE: rtl/core/rbsc_pkg.sv
// Shared constants, types and helpers for the ray/box slab clipper.
`timescale 1ns / 1ps
package rbsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int PROD_W    = DIFF_W + DATA_W;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DATA_W-1:0] Q_INF = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z_HIGH = 3'd5;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } slab_en_t;

  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
  } merge_en_t;

  // scale a raw product back to Q format and clamp to the data width
  function automatic logic signed [DATA_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic                     in_range;
    s        = p >>> FRAC_BITS;
    in_range = (&s[PROD_W-1:DATA_W-1]) || !(|s[PROD_W-1:DATA_W-1]);
    if (in_range) begin
      scale_sat = s[DATA_W-1:0];
    end else if (s[PROD_W-1]) begin
      scale_sat = Q_NEG;
    end else begin
      scale_sat = Q_INF;
    end
  endfunction

endpackage

FILE: rtl/core/rbsc_slab.sv
// One axis of the slab test: bound select, difference, product, scale and clamp.
`timescale 1ns / 1ps
module rbsc_slab import rbsc_pkg::*; (
  input  logic                     clk_i,
  input  slab_en_t                 en_i,
  input  logic signed [DATA_W-1:0] low_i,
  input  logic signed [DATA_W-1:0] high_i,
  input  logic signed [DATA_W-1:0] org_i,
  input  logic signed [DATA_W-1:0] inv_i,
  output logic signed [DATA_W-1:0] t_near_o,
  output logic signed [DATA_W-1:0] t_far_o
);

  logic signed [DATA_W-1:0] bnd_near, bnd_far;
  logic signed [DIFF_W-1:0] d_near_d, d_far_d, d_near_q, d_far_q;
  logic signed [DATA_W-1:0] inv_q;
  logic signed [PROD_W-1:0] p_near_d, p_far_d, p_near_q, p_far_q;
  logic signed [DATA_W-1:0] t_near_d, t_far_d, t_near_q, t_far_q;

  // negative inverse direction swaps the bounds; zero counts as positive
  always_comb begin
    bnd_near = inv_i[DATA_W-1] ? high_i : low_i;
    bnd_far  = inv_i[DATA_W-1] ? low_i  : high_i;
    d_near_d = DIFF_W'(bnd_near) - DIFF_W'(org_i);
    d_far_d  = DIFF_W'(bnd_far)  - DIFF_W'(org_i);
  end

  always_comb begin
    p_near_d = PROD_W'(d_near_q) * PROD_W'(inv_q);
    p_far_d  = PROD_W'(d_far_q)  * PROD_W'(inv_q);
  end

  always_comb begin
    t_near_d = scale_sat(p_near_q);
    t_far_d  = scale_sat(p_far_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      d_near_q <= d_near_d;
      d_far_q  <= d_far_d;
      inv_q    <= inv_i;
    end
    if (en_i.s2) begin
      p_near_q <= p_near_d;
      p_far_q  <= p_far_d;
    end
    if (en_i.s3) begin
      t_near_q <= t_near_d;
      t_far_q  <= t_far_d;
    end
  end

  assign t_near_o = t_near_q;
  assign t_far_o  = t_far_q;

endmodule

FILE: rtl/core/rbsc_merge.sv
// Interval merge across the three axes, rejection tests and final clip.
`timescale 1ns / 1ps
module rbsc_merge import rbsc_pkg::*; (
  input  logic                     clk_i,
  input  merge_en_t                en_i,
  input  logic signed [DATA_W-1:0] x_near_i,
  input  logic signed [DATA_W-1:0] x_far_i,
  input  logic signed [DATA_W-1:0] y_near_i,
  input  logic signed [DATA_W-1:0] y_far_i,
  input  logic signed [DATA_W-1:0] z_near_i,
  input  logic signed [DATA_W-1:0] z_far_i,
  input  logic signed [DATA_W-1:0] ray_near_i,
  input  logic signed [DATA_W-1:0] ray_far_i,
  output logic                     hit_o,
  output logic signed [DATA_W-1:0] clipped_near_o,
  output logic signed [DATA_W-1:0] clipped_far_o
);

  // stage 4: x/y merge
  logic                     miss4_d, miss4_q;
  logic signed [DATA_W-1:0] tmin4_d, tmax4_d, tmin4_q, tmax4_q;
  logic signed [DATA_W-1:0] zn4_q, zf4_q, rn4_q, rf4_q;
  // stage 5: z merge
  logic                     miss5_d, miss5_q;
  logic signed [DATA_W-1:0] tmin5_d, tmax5_d, tmin5_q, tmax5_q;
  logic signed [DATA_W-1:0] rn5_q, rf5_q;
  // stage 6: final test and clip
  logic                     hit6_d, hit6_q;
  logic signed [DATA_W-1:0] cn6_d, cf6_d, cn6_q, cf6_q;

  always_comb begin
    miss4_d = (x_near_i > y_far_i) || (y_near_i > x_far_i);
    tmin4_d = (y_near_i > x_near_i) ? y_near_i : x_near_i;
    tmax4_d = (y_far_i < x_far_i) ? y_far_i : x_far_i;
  end

  always_comb begin
    miss5_d = miss4_q || (tmin4_q > zf4_q) || (zn4_q > tmax4_q);
    tmin5_d = (zn4_q > tmin4_q) ? zn4_q : tmin4_q;
    tmax5_d = (zf4_q < tmax4_q) ? zf4_q : tmax4_q;
  end

  // entry at infinity or exit at or behind the origin rejects the ray
  always_comb begin
    hit6_d = !miss5_q && (tmin5_q != Q_INF) && !tmax5_q[DATA_W-1] && (|tmax5_q);
    cn6_d  = (hit6_d && (tmin5_q > rn5_q)) ? tmin5_q : rn5_q;
    cf6_d  = (hit6_d && (tmax5_q < rf5_q)) ? tmax5_q : rf5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      miss4_q <= miss4_d;
      tmin4_q <= tmin4_d;
      tmax4_q <= tmax4_d;
      zn4_q   <= z_near_i;
      zf4_q   <= z_far_i;
      rn4_q   <= ray_near_i;
      rf4_q   <= ray_far_i;
    end
    if (en_i.s5) begin
      miss5_q <= miss5_d;
      tmin5_q <= tmin5_d;
      tmax5_q <= tmax5_d;
      rn5_q   <= rn4_q;
      rf5_q   <= rf4_q;
    end
    if (en_i.s6) begin
      hit6_q <= hit6_d;
      cn6_q  <= cn6_d;
      cf6_q  <= cf6_d;
    end
  end

  assign hit_o          = hit6_q;
  assign clipped_near_o = cn6_q;
  assign clipped_far_o  = cf6_q;

endmodule

FILE: rtl/core/ray_box_slab_clip_core.sv
// Top level of the ray/axis-aligned-box slab clipper.
//
// Usage: write the six box bounds (x low/high, y low/high, z low/high, signed
// Q16.16) through cfg_we_i / cfg_idx_i / cfg_wdata_i while no ray is in flight.
// Rays enter on the input channel (in_valid_i / in_stall_o): origin, inverse
// direction and the current [near, far] interval. Each ray gives exactly one
// result on the output channel (out_valid_o / out_stall_i): a hit flag and the
// clipped interval, or the interval unchanged on a miss.
// Pipeline: six register stages (difference, product, scale/clamp, x/y merge,
// z merge, final test and clip).
// Throughput: one ray per cycle while the output does not stall. The six
// multipliers, one per bound and axis, sit in their own stage.
// Each stage has its own valid bit and loads when it is empty or its
// successor moves, so a stall on the output only backs up full stages;
// bubbles are squeezed out and nothing is dropped or duplicated.
// Reset clears all valid bits and sets every box bound to zero.
`timescale 1ns / 1ps
module ray_box_slab_clip_core import rbsc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [DATA_W-1:0]           cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [DATA_W-1:0]    origin_x_i,
  input  logic signed [DATA_W-1:0]    origin_y_i,
  input  logic signed [DATA_W-1:0]    origin_z_i,
  input  logic signed [DATA_W-1:0]    inv_dir_x_i,
  input  logic signed [DATA_W-1:0]    inv_dir_y_i,
  input  logic signed [DATA_W-1:0]    inv_dir_z_i,
  input  logic signed [DATA_W-1:0]    ray_near_i,
  input  logic signed [DATA_W-1:0]    ray_far_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic signed [DATA_W-1:0]    clipped_near_o,
  output logic signed [DATA_W-1:0]    clipped_far_o
);

  localparam int NSTG = 6;

  logic signed [DATA_W-1:0] box_x_low_q, box_x_high_q;
  logic signed [DATA_W-1:0] box_y_low_q, box_y_high_q;
  logic signed [DATA_W-1:0] box_z_low_q, box_z_high_q;

  logic [NSTG-1:0] vld_q, vld_d, ready;
  slab_en_t        slab_en;
  merge_en_t       merge_en;

  logic signed [DATA_W-1:0] rn1_q, rf1_q, rn2_q, rf2_q, rn3_q, rf3_q;
  logic signed [DATA_W-1:0] xn, xf, yn, yf, zn, zf;

  // box bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_low_q  <= '0;
      box_x_high_q <= '0;
      box_y_low_q  <= '0;
      box_y_high_q <= '0;
      box_z_low_q  <= '0;
      box_z_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOX_X_LOW:  box_x_low_q  <= cfg_wdata_i;
        REG_BOX_X_HIGH: box_x_high_q <= cfg_wdata_i;
        REG_BOX_Y_LOW:  box_y_low_q  <= cfg_wdata_i;
        REG_BOX_Y_HIGH: box_y_high_q <= cfg_wdata_i;
        REG_BOX_Z_LOW:  box_z_low_q  <= cfg_wdata_i;
        REG_BOX_Z_HIGH: box_z_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on
  always_comb begin
    ready[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ready[k] = !vld_q[k] || ready[k+1];
    end
    vld_d = vld_q;
    if (ready[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ready[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    slab_en.s1  = ready[0];
    slab_en.s2  = ready[1];
    slab_en.s3  = ready[2];
    merge_en.s4 = ready[3];
    merge_en.s5 = ready[4];
    merge_en.s6 = ready[5];
  end

  // ray interval rides alongside the slab stages
  always_ff @(posedge clk_i) begin
    if (slab_en.s1) begin
      rn1_q <= ray_near_i;
      rf1_q <= ray_far_i;
    end
    if (slab_en.s2) begin
      rn2_q <= rn1_q;
      rf2_q <= rf1_q;
    end
    if (slab_en.s3) begin
      rn3_q <= rn2_q;
      rf3_q <= rf2_q;
    end
  end

  rbsc_slab u_slab_x (
    .clk_i    (clk_i),
    .en_i     (slab_en),
    .low_i    (box_x_low_q),
    .high_i   (box_x_high_q),
    .org_i    (origin_x_i),
    .inv_i    (inv_dir_x_i),
    .t_near_o (xn),
    .t_far_o  (xf)
  );

  rbsc_slab u_slab_y (
    .clk_i    (clk_i),
    .en_i     (slab_en),
    .low_i    (box_y_low_q),
    .high_i   (box_y_high_q),
    .org_i    (origin_y_i),
    .inv_i    (inv_dir_y_i),
    .t_near_o (yn),
    .t_far_o  (yf)
  );

  rbsc_slab u_slab_z (
    .clk_i    (clk_i),
    .en_i     (slab_en),
    .low_i    (box_z_low_q),
    .high_i   (box_z_high_q),
    .org_i    (origin_z_i),
    .inv_i    (inv_dir_z_i),
    .t_near_o (zn),
    .t_far_o  (zf)
  );

  rbsc_merge u_merge (
    .clk_i          (clk_i),
    .en_i           (merge_en),
    .x_near_i       (xn),
    .x_far_i        (xf),
    .y_near_i       (yn),
    .y_far_i        (yf),
    .z_near_i       (zn),
    .z_far_i        (zf),
    .ray_near_i     (rn3_q),
    .ray_far_i      (rf3_q),
    .hit_o          (hit_o),
    .clipped_near_o (clipped_near_o),
    .clipped_far_o  (clipped_far_o)
  );

  assign in_stall_o  = !ready[0];
  assign out_valid_o = vld_q[NSTG-1];

  a_empty_entry_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> !in_stall_o)
    else $error("input stalled with empty first stage");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted transaction not captured");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTG-1] && !out_stall_i && !vld_q[NSTG-2]) |=> !vld_q[NSTG-1])
    else $error("delivered result repeated");

endmodule
